@@ rtl/roi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package roi_pkg;

	localparam int QUAT_BITS = 14;
	// rotation entry width after rounding to Q.14 (range about +-2^18)
	localparam int M_W       = 20;
	// quotient magnitude bits below the saturation point
	localparam int DIV_QBITS = 31;
	// operand stage + one stage per quotient bit + result stage
	localparam int DIV_LAT   = DIV_QBITS + 2;

	typedef enum logic [2:0] {
		REG_ORG_X = 3'd0,
		REG_ORG_Y = 3'd1,
		REG_ORG_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5,
		REG_TOL   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0]        half_x;
		logic [30:0]        half_y;
		logic [30:0]        half_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} box_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [30:0]        hit_distance;
	} result_t;

	typedef struct packed {
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
		logic [15:0]      tol;
	} cfg_t;

	// box-space ray plus what the back end needs of the box
	typedef struct packed {
		logic [8:0][M_W-1:0] m;
		logic [2:0][31:0]    center;
		logic [2:0][30:0]    half;
		logic [2:0][31:0]    lo;
		logic [2:0][31:0]    ld;
	} local_t;

	typedef struct packed {
		logic nz;
		logic neg;
	} div_flag_t;

	// Q.28 -> Q.14, half away from zero
	function automatic logic signed [M_W-1:0] rnd_q14_m(input logic signed [33:0] v);
		logic signed [34:0] t;
		t = 35'(v) + 35'(1 << (QUAT_BITS - 1)) - 35'(v[33]);
		return M_W'(t >>> QUAT_BITS);
	endfunction

	// matrix-vector sum >> 14, half away from zero
	function automatic logic signed [41:0] rnd_q14_acc(input logic signed [54:0] v);
		logic signed [55:0] t;
		t = 56'(v) + 56'(1 << (QUAT_BITS - 1)) - 56'(v[54]);
		return 42'(t >>> QUAT_BITS);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		logic signed [31:0] r;
		if (v > 44'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -44'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ray_obb_intersect_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ray against oriented box test engine.
// One ray (origin, direction, tolerance) sits in seven config registers,
// written through wr_en / wr_index / wr_data while the engine is idle.
// Boxes come in on a queue-style port: a word is taken when push is high
// and full is low. Results leave the same way: the oldest result is on
// 'result' while empty is low and is taken when pop is high.
// Throughput: one box per cycle, sustained, with pop held high.
// From accept to the port a box passes the front pipe (5 stages), the
// mid queue write, 33 divider stages (operand stage, one quotient bit
// per stage, result stage; three dividers in parallel) and 5 back stages.
// Front and back are split by a MID_DEPTH word queue; each half stalls on
// its own when the next one is full. A stalled receiver fills the
// OUT_DEPTH result queue, then the back end holds, then the mid queue,
// then full rises. Nothing is dropped.
// Reset: all queues empty, pipes hold no words, registers return to
// origin 0, direction (0,0,1.0), tolerance 66.
module ray_obb_intersect_top import roi_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  box_t        box,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	cfg_t    cfg_q;
	logic    mid_push, mid_pop, mid_empty, mid_full;
	local_t  mid_wdata, mid_rdata;
	logic    res_push, res_full;
	result_t res_word;

	// config registers; index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.org    <= '0;
			cfg_q.dir[0] <= '0;
			cfg_q.dir[1] <= '0;
			cfg_q.dir[2] <= 32'(1) << FRAC_BITS;
			cfg_q.tol    <= 16'd66;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ORG_X: cfg_q.org[0] <= wr_data;
				REG_ORG_Y: cfg_q.org[1] <= wr_data;
				REG_ORG_Z: cfg_q.org[2] <= wr_data;
				REG_DIR_X: cfg_q.dir[0] <= wr_data;
				REG_DIR_Y: cfg_q.dir[1] <= wr_data;
				REG_DIR_Z: cfg_q.dir[2] <= wr_data;
				REG_TOL:   cfg_q.tol    <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// front: rotation build + ray into box space
	roi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.box    (box),
		.full   (full),
		.q_push (mid_push),
		.q_word (mid_wdata),
		.q_full (mid_full)
	);

	roi_fifo #(.T(local_t), .DEPTH(MID_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.full   (mid_full)
	);

	// back: slab divide, entry t, bounds, world point
	roi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (mid_empty),
		.q_word  (mid_rdata),
		.q_pop   (mid_pop),
		.r_push  (res_push),
		.r_word  (res_word),
		.r_full  (res_full)
	);

	// result queue parts the back end from the receiver
	roi_fifo #(.T(result_t), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_word),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (res_full)
	);

endmodule

`default_nettype wire

@@ rtl/roi_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module roi_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	input  logic pop,
	output T     rdata,
	output logic empty,
	output logic full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T               mem_q [DEPTH];
	logic [AW-1:0]  wp_q;
	logic [AW-1:0]  rp_q;
	logic [AW:0]    cnt_q;
	logic           do_push;
	logic           do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (AW + 1)'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ rtl/roi_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// t = sat32(sign * (num << FRAC_BITS) / den), truncated; -1.0 when den is zero.
module roi_div import roi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [32:0]        num_abs,
	input  logic [31:0]        den_abs,
	input  div_flag_t          flag_in,
	output logic signed [31:0] t
);

	localparam int NW = 33 + FRAC_BITS;
	localparam int WW = (NW > 63) ? NW + 1 : 64;
	localparam logic signed [31:0] T_NONE = -(32'sd1 <<< FRAC_BITS);

	logic [WW-1:0]        rem_s  [DIV_QBITS+1];
	logic [31:0]          den_s  [DIV_QBITS+1];
	logic [DIV_QBITS-1:0] quo_s  [DIV_QBITS+1];
	div_flag_t            flag_s [DIV_QBITS+1];
	logic                 ovf_s  [DIV_QBITS+1];
	logic [WW-1:0]        nsh;
	logic [WW-1:0]        dsh    [DIV_QBITS+1];
	logic signed [31:0]   t_s;

	assign nsh = WW'(num_abs) << FRAC_BITS;

	always_comb begin
		dsh[0] = WW'(den_abs) << DIV_QBITS;
		for (int j = 1; j <= DIV_QBITS; j++) begin
			dsh[j] = WW'(den_s[j-1]) << (DIV_QBITS - j);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= nsh;
			den_s[0]  <= den_abs;
			quo_s[0]  <= '0;
			flag_s[0] <= flag_in;
			ovf_s[0]  <= (nsh >= dsh[0]);
			for (int j = 1; j <= DIV_QBITS; j++) begin
				den_s[j]  <= den_s[j-1];
				flag_s[j] <= flag_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				if (rem_s[j-1] >= dsh[j]) begin
					rem_s[j] <= rem_s[j-1] - dsh[j];
					quo_s[j] <= quo_s[j-1] | (DIV_QBITS'(1) << (DIV_QBITS - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					quo_s[j] <= quo_s[j-1];
				end
			end
			if (!flag_s[DIV_QBITS].nz) begin
				t_s <= T_NONE;
			end else if (ovf_s[DIV_QBITS]) begin
				t_s <= flag_s[DIV_QBITS].neg ? 32'sh80000000 : 32'sh7fffffff;
			end else if (flag_s[DIV_QBITS].neg) begin
				t_s <= -$signed(32'(quo_s[DIV_QBITS]));
			end else begin
				t_s <= $signed(32'(quo_s[DIV_QBITS]));
			end
		end
	end

	assign t = t_s;

endmodule

`default_nettype wire

@@ rtl/roi_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Front end: takes a box, builds its rotation, moves the ray into box space.
module roi_front import roi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   push,
	input  box_t   box,
	output logic   full,
	output logic   q_push,
	output local_t q_word,
	input  logic   q_full
);

	localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	box_t               box_s1, box_s2, box_s3, box_s4;
	logic signed [31:0] pr_s2  [9];
	logic signed [32:0] rel_s2 [3];
	logic signed [32:0] rel_s3 [3];
	logic signed [M_W-1:0] m_s3 [9];
	logic signed [M_W-1:0] m_s4 [9];
	logic signed [52:0] pl_s4 [3][3];
	logic signed [52:0] pd_s4 [3][3];
	local_t             word_s5;

	logic signed [31:0] c_s1 [3];
	logic signed [33:0] p34  [9];
	logic signed [33:0] mraw [9];
	logic signed [54:0] acc_l [3];
	logic signed [54:0] acc_d [3];

	// whole front moves together; stalls only when its last word can't leave
	assign en     = !(v_s5 && q_full);
	assign full   = !en;
	assign q_push = v_s5 && en;
	assign q_word = word_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign c_s1[0] = box_s1.center_x;
	assign c_s1[1] = box_s1.center_y;
	assign c_s1[2] = box_s1.center_z;

	// quaternion products -> Q.28 matrix
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			p34[k] = 34'(pr_s2[k]);
		end
		mraw[0] = ONE_Q28 - 34'sd2 * (p34[1] + p34[2]);
		mraw[1] = 34'sd2 * (p34[3] - p34[8]);
		mraw[2] = 34'sd2 * (p34[4] + p34[7]);
		mraw[3] = 34'sd2 * (p34[3] + p34[8]);
		mraw[4] = ONE_Q28 - 34'sd2 * (p34[0] + p34[2]);
		mraw[5] = 34'sd2 * (p34[5] - p34[6]);
		mraw[6] = 34'sd2 * (p34[4] - p34[7]);
		mraw[7] = 34'sd2 * (p34[5] + p34[6]);
		mraw[8] = ONE_Q28 - 34'sd2 * (p34[0] + p34[1]);
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_l[r] = 55'(pl_s4[r][0]) + 55'(pl_s4[r][1]) + 55'(pl_s4[r][2]);
			acc_d[r] = 55'(pd_s4[r][0]) + 55'(pd_s4[r][1]) + 55'(pd_s4[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s1 <= box;

			// order: xx yy zz xy xz yz wx wy wz
			pr_s2[0] <= $signed(box_s1.quat_x) * $signed(box_s1.quat_x);
			pr_s2[1] <= $signed(box_s1.quat_y) * $signed(box_s1.quat_y);
			pr_s2[2] <= $signed(box_s1.quat_z) * $signed(box_s1.quat_z);
			pr_s2[3] <= $signed(box_s1.quat_x) * $signed(box_s1.quat_y);
			pr_s2[4] <= $signed(box_s1.quat_x) * $signed(box_s1.quat_z);
			pr_s2[5] <= $signed(box_s1.quat_y) * $signed(box_s1.quat_z);
			pr_s2[6] <= $signed(box_s1.quat_w) * $signed(box_s1.quat_x);
			pr_s2[7] <= $signed(box_s1.quat_w) * $signed(box_s1.quat_y);
			pr_s2[8] <= $signed(box_s1.quat_w) * $signed(box_s1.quat_z);
			for (int i = 0; i < 3; i++) begin
				rel_s2[i] <= 33'($signed(cfg.org[i])) - 33'(c_s1[i]);
			end
			box_s2 <= box_s1;

			for (int k = 0; k < 9; k++) begin
				m_s3[k] <= rnd_q14_m(mraw[k]);
			end
			rel_s3 <= rel_s2;
			box_s3 <= box_s2;

			// transposed product: local = m^T * v
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pl_s4[r][c] <= m_s3[c*3+r] * rel_s3[c];
					pd_s4[r][c] <= m_s3[c*3+r] * 33'($signed(cfg.dir[c]));
				end
			end
			m_s4   <= m_s3;
			box_s4 <= box_s3;

			for (int r = 0; r < 3; r++) begin
				word_s5.lo[r] <= sat32(44'(rnd_q14_acc(acc_l[r])));
				word_s5.ld[r] <= sat32(44'(rnd_q14_acc(acc_d[r])));
			end
			for (int k = 0; k < 9; k++) begin
				word_s5.m[k] <= m_s4[k];
			end
			word_s5.center[0] <= box_s4.center_x;
			word_s5.center[1] <= box_s4.center_y;
			word_s5.center[2] <= box_s4.center_z;
			word_s5.half[0]   <= box_s4.half_x;
			word_s5.half[1]   <= box_s4.half_y;
			word_s5.half[2]   <= box_s4.half_z;
		end
	end

endmodule

`default_nettype wire

@@ rtl/roi_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Back end: slab t per axis, entry t, bounds check, world hit point.
module roi_back import roi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_empty,
	input  local_t  q_word,
	output logic    q_pop,
	output logic    r_push,
	output result_t r_word,
	input  logic    r_full
);

	localparam int PW = 66 - FRAC_BITS;
	localparam int BW = PW + 2;
	localparam logic [64:0] HALF_F = 65'(1) << (FRAC_BITS - 1);

	logic en;

	// divider operands
	logic signed [33:0] num   [3];
	logic signed [32:0] ld33  [3];
	logic [32:0]        n_abs [3];
	logic [31:0]        d_abs [3];
	div_flag_t          flg   [3];
	logic signed [31:0] t_ax  [3];

	// side line alongside the divider
	local_t side_s [1:DIV_LAT];
	logic   vd_s   [1:DIV_LAT];

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	local_t             w_s1, w_s2, w_s3, w_s4;
	logic signed [31:0] tmax_s1, tmax_s2, tmax_s3, tmax_s4;
	logic signed [63:0] prod_s2 [3];
	logic signed [32:0] p_s3 [3];
	logic               inb_s3, inb_s4;
	logic               tneg_s3, tneg_s4;
	logic signed [52:0] wp_s4 [3][3];
	result_t            res_s5;

	logic signed [31:0] tm01, tmax;
	logic signed [64:0] rt  [3];
	logic signed [PW-1:0] pp [3];
	logic signed [16:0] eps_s;
	logic signed [31:0] half_s [3];
	logic [2:0]         outb;
	logic signed [54:0] acc [3];
	logic signed [31:0] wpt [3];

	assign en     = !(v_s5 && r_full);
	assign q_pop  = en && !q_empty;
	assign r_push = en && v_s5;
	assign r_word = res_s5;

	// entry plane: -half when moving up the axis, +half when moving down
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ld33[i] = 33'($signed(q_word.ld[i]));
			if ($signed(q_word.ld[i]) > 32'sd0) begin
				num[i] = -34'($signed({1'b0, q_word.half[i]})) - 34'($signed(q_word.lo[i]));
			end else begin
				num[i] = 34'($signed({1'b0, q_word.half[i]})) - 34'($signed(q_word.lo[i]));
			end
			n_abs[i]  = num[i][33] ? 33'(-num[i]) : 33'(num[i]);
			d_abs[i]  = ld33[i][32] ? 32'(-ld33[i]) : 32'(ld33[i]);
			flg[i].nz  = (q_word.ld[i] != '0);
			flg[i].neg = num[i][33] ^ q_word.ld[i][31];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		roi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk     (clk),
			.en      (en),
			.num_abs (n_abs[i]),
			.den_abs (d_abs[i]),
			.flag_in (flg[i]),
			.t       (t_ax[i])
		);
	end

	always_comb begin
		tm01 = (t_ax[0] > t_ax[1]) ? t_ax[0] : t_ax[1];
		tmax = (tm01 > t_ax[2]) ? tm01 : t_ax[2];
	end

	// hit point and bounds check
	always_comb begin
		eps_s = $signed({1'b0, cfg.tol});
		for (int i = 0; i < 3; i++) begin
			half_s[i] = $signed({1'b0, w_s2.half[i]});
			rt[i] = 65'(prod_s2[i]) + $signed(HALF_F) - 65'(prod_s2[i][63]);
			pp[i] = PW'(rt[i] >>> FRAC_BITS) + PW'($signed(w_s2.lo[i]));
			outb[i] = (BW'(pp[i]) + BW'(eps_s) < -BW'(half_s[i])) ||
			          (BW'(pp[i]) - BW'(eps_s) > BW'(half_s[i]));
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = 55'(wp_s4[r][0]) + 55'(wp_s4[r][1]) + 55'(wp_s4[r][2]);
			wpt[r] = sat32(44'(rnd_q14_acc(acc[r])) + 44'($signed(w_s4.center[r])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= DIV_LAT; j++) begin
				vd_s[j] <= 1'b0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			vd_s[1] <= !q_empty;
			for (int j = 2; j <= DIV_LAT; j++) begin
				vd_s[j] <= vd_s[j-1];
			end
			v_s1 <= vd_s[DIV_LAT];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= q_word;
			for (int j = 2; j <= DIV_LAT; j++) begin
				side_s[j] <= side_s[j-1];
			end

			tmax_s1 <= tmax;
			w_s1    <= side_s[DIV_LAT];

			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= $signed(w_s1.ld[i]) * tmax_s1;
			end
			tmax_s2 <= tmax_s1;
			w_s2    <= w_s1;

			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= pp[i][32:0];
			end
			inb_s3  <= (outb == 3'b000);
			tneg_s3 <= tmax_s2[31];
			tmax_s3 <= tmax_s2;
			w_s3    <= w_s2;

			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					wp_s4[r][c] <= $signed(w_s3.m[r*3+c]) * p_s3[c];
				end
			end
			inb_s4  <= inb_s3;
			tneg_s4 <= tneg_s3;
			tmax_s4 <= tmax_s3;
			w_s4    <= w_s3;

			if (inb_s4 && !tneg_s4) begin
				res_s5.hit          <= 1'b1;
				res_s5.point_x      <= wpt[0];
				res_s5.point_y      <= wpt[1];
				res_s5.point_z      <= wpt[2];
				res_s5.hit_distance <= tmax_s4[30:0];
			end else begin
				res_s5 <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/roi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module roi_checker import roi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input box_t        box,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input result_t     result,
	input logic        wr_en,
	input logic [2:0]  wr_index,
	input logic [31:0] wr_data
);

	// a waiting result stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result word dropped before pop");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("result word changed while waiting");

	// a miss carries no point
	a_miss_point: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.hit |->
			(result.point_x == 32'sd0 && result.point_y == 32'sd0 &&
			 result.point_z == 32'sd0))
		else $error("miss word with nonzero point");

	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.hit |-> result.hit_distance == 31'd0)
		else $error("miss word with nonzero distance");

endmodule

bind ray_obb_intersect_top roi_checker u_chk (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import roi_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam longint ONE_FX = longint'(1) << FRAC_BITS;
	// front end + mid queue + divider + back end, with slack
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        push;
	box_t        box;
	logic        full;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;

	ray_obb_intersect_top DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .box(box), .full(full),
		.empty(empty), .pop(pop), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// shadow copy of the ray registers
	logic [31:0] ray_org [3];
	logic [31:0] ray_dir [3];
	logic [15:0] ray_tol;

	result_t pending_hits [$];   // expected results, oldest first
	int      fail_count;
	int      cycle_count;
	int      snd_idle;           // percent of cycles the sender holds off
	int      rcv_idle;           // percent of cycles the receiver stalls

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint rnd_shr(longint v, int s);
		longint h;
		h = longint'(1) << (s - 1);
		if (v >= 0) return (v + h) >>> s;
		return -((-v + h) >>> s);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic result_t trace_box(box_t b);
		longint c[3], hf[3], rel[3], lo[3], ld[3], dv[3], p[3], wp[3];
		longint m[3][3];
		longint w, x, y, z, one, t, tbest, num, acc, eps;
		result_t r;
		r = '0;
		c[0] = longint'($signed(b.center_x));
		c[1] = longint'($signed(b.center_y));
		c[2] = longint'($signed(b.center_z));
		hf[0] = longint'(b.half_x);
		hf[1] = longint'(b.half_y);
		hf[2] = longint'(b.half_z);
		w = longint'($signed(b.quat_w));
		x = longint'($signed(b.quat_x));
		y = longint'($signed(b.quat_y));
		z = longint'($signed(b.quat_z));
		eps = longint'(ray_tol);
		for (int i = 0; i < 3; i++) begin
			dv[i] = longint'($signed(ray_dir[i]));
			rel[i] = longint'($signed(ray_org[i])) - c[i];
		end
		// rotation in Q.28, then rounded to Q.14
		one = longint'(1) << (2 * QUAT_BITS);
		m[0][0] = one - 2 * (y*y + z*z);
		m[0][1] = 2 * (x*y - w*z);
		m[0][2] = 2 * (x*z + w*y);
		m[1][0] = 2 * (x*y + w*z);
		m[1][1] = one - 2 * (x*x + z*z);
		m[1][2] = 2 * (y*z - w*x);
		m[2][0] = 2 * (x*z - w*y);
		m[2][1] = 2 * (y*z + w*x);
		m[2][2] = one - 2 * (x*x + y*y);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = rnd_shr(m[i][j], QUAT_BITS);
		// into box space with the transpose
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += m[j][i] * rel[j];
			lo[i] = clamp32(rnd_shr(acc, QUAT_BITS));
			acc = 0;
			for (int j = 0; j < 3; j++) acc += m[j][i] * dv[j];
			ld[i] = clamp32(rnd_shr(acc, QUAT_BITS));
		end
		// slab entry, largest t wins; zero direction gives -1.0
		tbest = -ONE_FX;
		for (int i = 0; i < 3; i++) begin
			t = -ONE_FX;
			if (ld[i] != 0) begin
				num = (ld[i] > 0) ? (-hf[i] - lo[i]) : (hf[i] - lo[i]);
				t = clamp32((num * ONE_FX) / ld[i]);
			end
			if (t > tbest) tbest = t;
		end
		if (tbest < 0) return r;
		for (int i = 0; i < 3; i++) begin
			p[i] = lo[i] + rnd_shr(ld[i] * tbest, FRAC_BITS);
			if (p[i] + eps < -hf[i] || p[i] - eps > hf[i]) return r;
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += m[i][j] * p[j];
			wp[i] = clamp32(rnd_shr(acc, QUAT_BITS) + c[i]);
		end
		r.hit = 1'b1;
		r.point_x = wp[0][31:0];
		r.point_y = wp[1][31:0];
		r.point_z = wp[2][31:0];
		r.hit_distance = tbest[30:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls, each popped word checked in order
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_hits.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				exp_r = pending_hits.pop_front();
				if (result.hit !== exp_r.hit) begin
					$error("hit: expected %0d actual %0d", exp_r.hit, result.hit);
					fail_count++;
				end
				if (result.point_x !== exp_r.point_x) begin
					$error("point_x: expected %0d actual %0d",
						exp_r.point_x, result.point_x);
					fail_count++;
				end
				if (result.point_y !== exp_r.point_y) begin
					$error("point_y: expected %0d actual %0d",
						exp_r.point_y, result.point_y);
					fail_count++;
				end
				if (result.point_z !== exp_r.point_z) begin
					$error("point_z: expected %0d actual %0d",
						exp_r.point_z, result.point_z);
					fail_count++;
				end
				if (result.hit_distance !== exp_r.hit_distance) begin
					$error("hit_distance: expected %0d actual %0d",
						exp_r.hit_distance, result.hit_distance);
					fail_count++;
				end
			end
		end
		pop <= arst_n && ($urandom_range(99) >= rcv_idle);
	end

	// ------------------------------------------------------------------
	// Shared tasks
	// ------------------------------------------------------------------
	// push one box word; push stays high afterwards unless the next call idles
	task automatic send_box(box_t b);
		while ($urandom_range(99) < snd_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		box <= b;
		do @(posedge clk); while (full);
		pending_hits.push_back(trace_box(b));
	endtask

	// wait until every expected word is out and the pipe has emptied
	task automatic drain();
		push <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_ORG_X, REG_ORG_Y, REG_ORG_Z: ray_org[int'(idx)] = val;
			REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[int'(idx) - 3] = val;
			REG_TOL: ray_tol = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [15:0] tol);
		write_reg(REG_ORG_X, ox);
		write_reg(REG_ORG_Y, oy);
		write_reg(REG_ORG_Z, oz);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_TOL, {16'd0, tol});
	endtask

	function automatic logic [31:0] fx(real v);
		return 32'($rtoi(v * 65536.0));
	endfunction

	function automatic real urand_real(real lo_v, real hi_v);
		return lo_v + (hi_v - lo_v) * ($urandom_range(1000000) / 1000000.0);
	endfunction

	function automatic box_t make_box(real cx, real cy, real cz, real hx, real hy,
			real hz, logic [15:0] qw, logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
		box_t b;
		b.center_x = fx(cx);
		b.center_y = fx(cy);
		b.center_z = fx(cz);
		b.half_x = 31'(fx(hx));
		b.half_y = 31'(fx(hy));
		b.half_z = 31'(fx(hz));
		b.quat_w = qw;
		b.quat_x = qx;
		b.quat_y = qy;
		b.quat_z = qz;
		return b;
	endfunction

	// box placed along the current ray, unit quaternion, modest sizes
	function automatic box_t aimed_box();
		real k, n, q[4];
		real o[3], d[3];
		box_t b;
		for (int i = 0; i < 3; i++) begin
			o[i] = $itor($signed(ray_org[i])) / 65536.0;
			d[i] = $itor($signed(ray_dir[i])) / 65536.0;
		end
		k = urand_real(-2.0, 25.0);
		n = 0.0;
		for (int i = 0; i < 4; i++) begin
			q[i] = urand_real(-1.0, 1.0);
			n += q[i] * q[i];
		end
		n = (n < 1e-6) ? 1.0 : $sqrt(n);
		b = make_box(o[0] + d[0]*k + urand_real(-3.0, 3.0),
			o[1] + d[1]*k + urand_real(-3.0, 3.0),
			o[2] + d[2]*k + urand_real(-3.0, 3.0),
			urand_real(0.0, 6.0), urand_real(0.0, 6.0), urand_real(0.0, 6.0),
			16'($rtoi(q[0] / n * 16384.0)), 16'($rtoi(q[1] / n * 16384.0)),
			16'($rtoi(q[2] / n * 16384.0)), 16'($rtoi(q[3] / n * 16384.0)));
		return b;
	endfunction

	function automatic box_t noise_box();
		logic [255:0] raw;
		box_t b;
		raw = {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		b = raw[$bits(box_t)-1:0];
		// bias toward field extremes now and then
		if ($urandom_range(3) == 0) b.half_x = '1;
		if ($urandom_range(3) == 0) b.center_y = 32'h8000_0000;
		if ($urandom_range(3) == 0) b.quat_z = 16'h7fff;
		return b;
	endfunction

	function automatic logic [31:0] rand_dir_comp();
		case ($urandom_range(5))
			0: return 32'd0;   // ray perpendicular to this axis
			default: return fx(urand_real(-2.0, 2.0));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		box_t b;
		snd_idle = 0;
		rcv_idle = 0;
		// reset ray: origin 0, direction +z
		send_box(make_box(0, 0, 10, 1, 1, 1, 16384, 0, 0, 0));   // plain hit
		send_box(make_box(0, 0, 0, 1, 1, 1, 16384, 0, 0, 0));    // origin inside: miss
		send_box(make_box(0, 0, -10, 1, 1, 1, 16384, 0, 0, 0));  // behind: miss
		send_box(make_box(0.5, 0, 5, 1, 2, 1, 11585, 0, 0, 11585)); // 90 deg about z
		send_box(make_box(1, 1, 8, 2, 2, 2, 11585, 11585, 0, 0));   // 90 deg about x
		send_box(make_box(0, 0, 4, 1, 1, 1, 0, 0, 0, 0));        // zero quaternion
		send_box(make_box(0, 0, 4, 1, 1, 1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_box(make_box(0, 0, 4, 1, 1, 1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_box(make_box(0, 1.0, 6, 1, 1, 1, 16384, 0, 0, 0));  // grazing edge
		send_box('0);
		send_box('1);
		b = make_box(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
		b.center_z = 32'h7fff_ffff;
		b.half_x = '1; b.half_y = '1; b.half_z = '1;
		send_box(b);
		b.center_x = 32'h8000_0000; b.center_y = 32'h8000_0000;
		b.center_z = 32'h8000_0000;
		send_box(b);
		drain();
		// no direction at all: every axis gives -1, always a miss
		write_reg(REG_DIR_Z, 32'd0);
		send_box(make_box(0, 0, 10, 1, 1, 1, 16384, 0, 0, 0));
		drain();
		// extreme ray, widest tolerance: saturation in t and world point
		set_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'd1, 16'hffff);
		send_box(make_box(0, 0, 0, 1, 1, 1, 16384, 0, 0, 0));
		b = '0; b.quat_w = 16'd16384;
		b.half_x = '1; b.half_y = '1; b.half_z = '1;
		send_box(b);
		send_box(noise_box());
		drain();
		// zero tolerance, box face exactly at the point
		set_ray(fx(-5), fx(0.25), 0, fx(1), 0, 0, 16'd0);
		send_box(make_box(0, 0, 0, 1, 0.25, 1, 16384, 0, 0, 0));
		send_box(make_box(0, 0, 0, 1, 0.2499, 1, 16384, 0, 0, 0));
		send_box(make_box(3, 0, 0, 0.5, 0.5, 0.5, 16384, 0, 0, 0));
		drain();
	endtask

	task automatic test_random(int snd_pct, int rcv_pct, int n_items);
		snd_idle = snd_pct;
		rcv_idle = rcv_pct;
		for (int i = 0; i < n_items; i++) begin
			// new ray every so often, only with the engine empty
			if (i % 150 == 0) begin
				drain();
				set_ray(fx(urand_real(-20, 20)), fx(urand_real(-20, 20)),
					fx(urand_real(-20, 20)), rand_dir_comp(), rand_dir_comp(),
					rand_dir_comp(), 16'($urandom_range(0, 400)));
			end
			if ($urandom_range(9) < 7) send_box(aimed_box());
			else send_box(noise_box());
			// runs with no hold-off at all
			if ($urandom_range(40) == 0) snd_idle = 0;
			if ($urandom_range(40) == 0) snd_idle = snd_pct;
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		box = '0;
		pop = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_ORG_X;
		wr_data = '0;
		fail_count = 0;
		cycle_count = 0;
		snd_idle = 0;
		rcv_idle = 0;
		ray_org[0] = '0; ray_org[1] = '0; ray_org[2] = '0;
		ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = 32'(ONE_FX);
		ray_tol = 16'd66;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(35, 80, 620);
		test_random(80, 35, 620);
		test_random(0, 0, 620);

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
